[rtl/core/lkvc_pkg.sv]
// Shared sizes, codes and helper functions of the key-value cache.
`timescale 1ns / 1ps

package lkvc_pkg;

   // Storage geometry.
   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 16;
   localparam int VALUE_BITS = 32;

   // Derived widths.
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int ENTRY_W = KEY_BITS + VALUE_BITS;

   // Port field widths.
   localparam int PORT_KEY_W   = 16;
   localparam int PORT_VALUE_W = 32;
   localparam int CAP_W        = 5;
   localparam int REQ_TDATA_W  = 48;
   localparam int RSP_TDATA_W  = 32;

   // Capacity register value after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Request kinds carried in tuser.
   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   // Keep the low KEY_BITS bits of a port key, zero-filling narrower keys.
   function automatic logic [KEY_BITS-1:0] key_of(input logic [PORT_KEY_W-1:0] k);
      logic [63:0] w;
      w = 64'(k);
      return w[KEY_BITS-1:0];
   endfunction

   // Keep the low VALUE_BITS bits of a port value.
   function automatic logic [VALUE_BITS-1:0] value_of(input logic [PORT_VALUE_W-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[VALUE_BITS-1:0];
   endfunction

   // Sign-extend a stored value to the port width.
   function automatic logic [PORT_VALUE_W-1:0] value_out(input logic [VALUE_BITS-1:0] v);
      logic signed [63:0] w;
      w = 64'($signed(v));
      return w[PORT_VALUE_W-1:0];
   endfunction

endpackage

[rtl/core/lkvc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module lkvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

[rtl/core/lru_key_value_cache.sv]
// Top level of the fully associative key-value cache with LRU replacement.
// Each request searches the store slot by slot; a hit or a put of a new key into a full store
// then shifts the younger entries down, and the entry is appended at the most recent end.
// Throughput: one request at a time; one slot is visited per cycle.
// A get result waits in an output register; the next get stalls until it has been taken.
// Synchronous active-high reset empties the store and sets the capacity to 16.
`timescale 1ns / 1ps

module lru_key_value_cache (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lkvc_pkg::REQ_TDATA_W-1:0]     req_tdata,  // [15:0] lookup_key, [47:16] store_value
   input  logic                                 req_tuser,  // [0] mode
   // Response channel.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lkvc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // [31:0] read_value
   output logic                                 rsp_tuser,  // [0] found
   // Capacity register.
   input  logic                                 csr_write_enable,
   input  logic [lkvc_pkg::CAP_W-1:0]           csr_write_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_WRITE,
      S_RESP
   } state_type;

   state_type                           state_ff, state_in;
   logic                                mode_ff, mode_in;
   logic [lkvc_pkg::KEY_BITS-1:0]       key_ff, key_in;
   logic [lkvc_pkg::VALUE_BITS-1:0]     val_ff, val_in;
   logic [lkvc_pkg::CNT_W-1:0]          fill_ff, fill_in;
   logic [lkvc_pkg::CNT_W-1:0]          scan_ff, scan_in;
   logic [lkvc_pkg::CNT_W-1:0]          dist_ff, dist_in;
   logic                                pend_ff, pend_in;
   logic [lkvc_pkg::IDX_W-1:0]          pidx_ff, pidx_in;
   logic                                hit_ff, hit_in;
   logic [lkvc_pkg::CAP_W-1:0]          cap_ff, cap_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_found_ff, rsp_found_in;
   logic [lkvc_pkg::PORT_VALUE_W-1:0]   rsp_value_ff, rsp_value_in;

   logic [lkvc_pkg::CNT_W-1:0]          cap_eff;
   logic                                match;
   logic                                ram_we;
   logic [lkvc_pkg::IDX_W-1:0]          ram_waddr;
   logic [lkvc_pkg::ENTRY_W-1:0]        ram_wdata;
   logic [lkvc_pkg::IDX_W-1:0]          ram_raddr;
   logic [lkvc_pkg::ENTRY_W-1:0]        ram_rdata;
   logic [lkvc_pkg::KEY_BITS-1:0]       rd_key;
   logic [lkvc_pkg::VALUE_BITS-1:0]     rd_value;
   logic [lkvc_pkg::CNT_W-1:0]          shift_dst;

   // Entry store: value in the upper bits, key in the lower bits.
   lkvc_ram #(
      .WIDTH(lkvc_pkg::ENTRY_W),
      .DEPTH(lkvc_pkg::ENTRIES)
   ) u_entries (
      .clock       (clock),
      .write_enable(ram_we),
      .write_addr  (ram_waddr),
      .write_data  (ram_wdata),
      .read_addr   (ram_raddr),
      .read_data   (ram_rdata)
   );

   assign rd_key   = ram_rdata[lkvc_pkg::KEY_BITS-1:0];
   assign rd_value = ram_rdata[lkvc_pkg::ENTRY_W-1:lkvc_pkg::KEY_BITS];

   // The slot read last cycle matches the requested key.
   assign match = pend_ff && (rd_key == key_ff);

   // Destination of a shifted entry: its source slot less the shift distance.
   assign shift_dst = lkvc_pkg::CNT_W'(pidx_ff) - dist_ff;

   // Capacity clamped to the range one to the number of slots.
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = lkvc_pkg::CNT_W'(1);
      end else if (32'(cap_ff) > lkvc_pkg::ENTRIES) begin
         cap_eff = lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES);
      end else begin
         cap_eff = lkvc_pkg::CNT_W'(cap_ff);
      end
   end

   // Sequencer: search slot by slot, shift younger entries down, append, respond to gets.
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      fill_in      = fill_ff;
      scan_in      = scan_ff;
      dist_in      = dist_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      hit_in       = hit_ff;
      cap_in       = cap_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = scan_ff[lkvc_pkg::IDX_W-1:0];

      if (csr_write_enable) begin
         cap_in = csr_write_data;
      end

      // The output register empties on a transfer.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               mode_in  = req_tuser;
               key_in   = lkvc_pkg::key_of(req_tdata[lkvc_pkg::PORT_KEY_W-1:0]);
               val_in   = lkvc_pkg::value_of(
                             req_tdata[lkvc_pkg::REQ_TDATA_W-1:lkvc_pkg::PORT_KEY_W]);
               scan_in  = '0;
               pend_in  = 1'b0;
               hit_in   = 1'b0;
               state_in = S_SEARCH;
            end
         end

         S_SEARCH: begin
            priority if (match) begin
               // Hit: remove the entry by shifting the younger ones down by one.
               hit_in   = 1'b1;
               pend_in  = 1'b0;
               if (mode_ff == lkvc_pkg::MODE_GET) begin
                  val_in = rd_value;
               end
               scan_in  = lkvc_pkg::CNT_W'(pidx_ff) + lkvc_pkg::CNT_W'(1);
               dist_in  = lkvc_pkg::CNT_W'(1);
               state_in = S_SHIFT;
            end else if (scan_ff < fill_ff) begin
               pend_in  = 1'b1;
               pidx_in  = scan_ff[lkvc_pkg::IDX_W-1:0];
               scan_in  = scan_ff + lkvc_pkg::CNT_W'(1);
            end else begin
               // Miss.
               pend_in = 1'b0;
               if (mode_ff == lkvc_pkg::MODE_GET) begin
                  state_in = S_RESP;
               end else if (fill_ff >= cap_eff) begin
                  // Drop the oldest entries so that the insert leaves the store at capacity.
                  dist_in  = fill_ff - cap_eff + lkvc_pkg::CNT_W'(1);
                  scan_in  = fill_ff - cap_eff + lkvc_pkg::CNT_W'(1);
                  state_in = S_SHIFT;
               end else begin
                  dist_in  = '0;
                  scan_in  = fill_ff;
                  state_in = S_WRITE;
               end
            end
         end

         S_SHIFT: begin
            // Write back the entry read last cycle at its lower slot.
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = shift_dst[lkvc_pkg::IDX_W-1:0];
               ram_wdata = ram_rdata;
            end
            if (scan_ff < fill_ff) begin
               pend_in = 1'b1;
               pidx_in = scan_ff[lkvc_pkg::IDX_W-1:0];
               scan_in = scan_ff + lkvc_pkg::CNT_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_WRITE;
               end
            end
         end

         S_WRITE: begin
            // Append at the most recent end.
            ram_we    = 1'b1;
            ram_waddr = lkvc_pkg::IDX_W'(fill_ff - dist_ff);
            ram_wdata = {val_ff, key_ff};
            fill_in   = fill_ff - dist_ff + lkvc_pkg::CNT_W'(1);
            if (mode_ff == lkvc_pkg::MODE_GET) begin
               state_in = S_RESP;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_value_in = hit_ff ? lkvc_pkg::value_out(val_ff) : '1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         cap_ff       <= lkvc_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      scan_ff      <= scan_in;
      dist_ff      <= dist_in;
      pidx_ff      <= pidx_in;
      hit_ff       <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_value_ff;

endmodule

[rtl/core/lkvc_checker.sv]
// Port-level checks of the key-value cache and their binding to the top level.
`timescale 1ns / 1ps

module lkvc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [lkvc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input logic                              req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [lkvc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              csr_write_enable,
   input logic [lkvc_pkg::CAP_W-1:0]        csr_write_data
);

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // A miss always reports all ones.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '1)
      else $error("miss without all-ones value");

   // The block does not accept a request in the cycle after a request transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // A response never appears in the cycle after a request is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response without a completed lookup");

   // Reset leaves no response pending.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response pending after reset");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

[dv/tb_lru_key_value_cache.sv]
// Self-checking testbench for the LRU key-value cache: directed and random lookups and stores.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

   // Cycles allowed for a request still in flight, after the last lookup result has arrived.
   localparam int SETTLE_CYCLES = 60;
   // Upper bound on the wait for outstanding lookup results at the end of the run.
   localparam int DRAIN_LIMIT   = 20000;
   // Only the first few mismatches are printed in full.
   localparam int REPORT_LIMIT  = 10;

   // One expected lookup result.
   typedef struct packed {
      logic                              found;
      logic [lkvc_pkg::PORT_VALUE_W-1:0] read_value;
   } lookup_result_type;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [lkvc_pkg::REQ_TDATA_W-1:0]  req_tdata;   // [15:0] lookup_key, [47:16] store_value
   logic                              req_tuser;   // [0] mode
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [lkvc_pkg::RSP_TDATA_W-1:0]  rsp_tdata;   // [31:0] read_value
   logic                              rsp_tuser;   // [0] found
   logic                              csr_write_enable;
   logic [lkvc_pkg::CAP_W-1:0]        csr_write_data;

   // Mirror of the cache contents, oldest entry in slot 0.
   logic [lkvc_pkg::KEY_BITS-1:0]     mirror_key[lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::VALUE_BITS-1:0]   mirror_value[lkvc_pkg::ENTRIES];
   int                                mirror_fill;
   logic [lkvc_pkg::CAP_W-1:0]        mirror_capacity;

   lookup_result_type                 pending_lookups[$];
   int                                mismatch_count;
   int                                sender_idle_pct;
   int                                receiver_stall_pct;

   lru_key_value_cache DUT (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Clock with a 2 ns period.
   always #1 clock = ~clock;

   // Capacity that actually applies: zero acts as one, anything above the store size as full.
   function automatic int usable_capacity();
      int cap;
      cap = int'(mirror_capacity);
      if (cap == 0) begin
         cap = 1;
      end
      if (cap > lkvc_pkg::ENTRIES) begin
         cap = lkvc_pkg::ENTRIES;
      end
      return cap;
   endfunction

   // Slot holding the key, or the fill level when the key is absent.
   function automatic int slot_of_key(input logic [lkvc_pkg::KEY_BITS-1:0] key);
      for (int i = 0; i < mirror_fill; i++) begin
         if (mirror_key[i] == key) begin
            return i;
         end
      end
      return mirror_fill;
   endfunction

   // Removes one entry; the younger entries move down by one slot.
   function automatic void remove_entry(input int pos);
      for (int i = pos; i + 1 < mirror_fill; i++) begin
         mirror_key[i]   = mirror_key[i + 1];
         mirror_value[i] = mirror_value[i + 1];
      end
      mirror_fill--;
   endfunction

   // Places an entry at the most recently used end.
   function automatic void append_entry(input logic [lkvc_pkg::KEY_BITS-1:0] key,
                                        input logic [lkvc_pkg::VALUE_BITS-1:0] value);
      mirror_key[mirror_fill]   = key;
      mirror_value[mirror_fill] = value;
      mirror_fill++;
   endfunction

   // Updates the mirror for one accepted request and records the lookup result it must give.
   function automatic void apply_request(input logic mode,
                                         input logic [lkvc_pkg::KEY_BITS-1:0] key,
                                         input logic [lkvc_pkg::VALUE_BITS-1:0] value);
      int                              pos;
      logic [lkvc_pkg::VALUE_BITS-1:0] hit_value;
      lookup_result_type               result;
      pos = slot_of_key(key);
      if (mode == lkvc_pkg::MODE_GET) begin
         if (pos < mirror_fill) begin
            hit_value = mirror_value[pos];
            remove_entry(pos);
            append_entry(key, hit_value);
            result.found      = 1'b1;
            result.read_value = lkvc_pkg::PORT_VALUE_W'($signed(hit_value));
         end else begin
            result.found      = 1'b0;
            result.read_value = '1;
         end
         pending_lookups.push_back(result);
      end else if (pos < mirror_fill) begin
         // A store to a present key refreshes it and never evicts.
         remove_entry(pos);
         append_entry(key, value);
      end else begin
         // A new key first trims the oldest entries down to below the capacity.
         while (mirror_fill >= usable_capacity()) begin
            remove_entry(0);
         end
         append_entry(key, value);
      end
   endfunction

   // Sends one request, after a random gap, and returns at the next falling edge.
   task automatic send_request(input logic mode, input logic [lkvc_pkg::PORT_KEY_W-1:0] key,
                               input logic [lkvc_pkg::PORT_VALUE_W-1:0] value);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {value, key};
      do begin
         @(posedge clock);
      end while (!req_tready);
      apply_request(mode, key[lkvc_pkg::KEY_BITS-1:0], value[lkvc_pkg::VALUE_BITS-1:0]);
      @(negedge clock);
   endtask

   // Holds the request channel until every outstanding lookup result has arrived.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_lookups.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Writes the capacity register once the block has gone idle.
   task automatic set_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      mirror_capacity = cap;
   endtask

   // Value with a bias towards the signed extremes.
   function automatic logic [lkvc_pkg::PORT_VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom();
      endcase
   endfunction

   // Lookups and stores on an empty store, at the key and value extremes, and an update.
   task automatic test_lookup_and_update();
      send_request(lkvc_pkg::MODE_GET, 16'h0000, 32'h0000_0000);
      send_request(lkvc_pkg::MODE_GET, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(lkvc_pkg::MODE_PUT, 16'h0000, 32'h8000_0000);
      send_request(lkvc_pkg::MODE_PUT, 16'hFFFF, 32'h7FFF_FFFF);
      send_request(lkvc_pkg::MODE_GET, 16'h0000, 32'h1234_5678);
      send_request(lkvc_pkg::MODE_GET, 16'hFFFF, 32'h0000_0000);
      send_request(lkvc_pkg::MODE_PUT, 16'h0000, 32'hFFFF_FFFF);
      send_request(lkvc_pkg::MODE_GET, 16'h0000, 32'h0000_0000);
      send_request(lkvc_pkg::MODE_GET, 16'h5A5A, 32'hDEAD_BEEF);
   endtask

   // Eviction at a small capacity, then a capacity of zero while the store holds more.
   task automatic test_capacity_trim();
      set_capacity(5'd4);
      send_request(lkvc_pkg::MODE_PUT, 16'h0011, 32'h0000_0011);
      send_request(lkvc_pkg::MODE_PUT, 16'h0022, 32'hFFFF_FF22);
      send_request(lkvc_pkg::MODE_PUT, 16'h0033, 32'h0000_0033);
      send_request(lkvc_pkg::MODE_PUT, 16'h0044, 32'h8000_0044);
      send_request(lkvc_pkg::MODE_GET, 16'h0011, 32'h0000_0000);
      set_capacity(5'd0);
      // Lookups and updates of present keys leave the over-full store as it is.
      send_request(lkvc_pkg::MODE_GET, 16'h0022, 32'h0000_0000);
      send_request(lkvc_pkg::MODE_PUT, 16'h0033, 32'h7FFF_0033);
      send_request(lkvc_pkg::MODE_GET, 16'h0044, 32'h0000_0000);
      send_request(lkvc_pkg::MODE_PUT, 16'h0055, 32'h0000_0055);
      send_request(lkvc_pkg::MODE_GET, 16'h0011, 32'h0000_0000);
      send_request(lkvc_pkg::MODE_GET, 16'h0055, 32'h0000_0000);
   endtask

   // Random lookups and stores, mostly on a small set of keys so that hits and evictions occur.
   task automatic test_random_traffic(input int count, input int pool_size);
      logic [lkvc_pkg::PORT_KEY_W-1:0] key_pool[32];
      logic [lkvc_pkg::PORT_KEY_W-1:0] key;
      for (int i = 0; i < pool_size; i++) begin
         key_pool[i] = lkvc_pkg::PORT_KEY_W'($urandom());
      end
      key_pool[0] = 16'h0000;
      if (pool_size > 2) begin
         key_pool[pool_size - 1] = 16'hFFFF;
      end
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 85) begin
            key = key_pool[$urandom_range(0, pool_size - 1)];
         end else begin
            key = lkvc_pkg::PORT_KEY_W'($urandom());
         end
         send_request($urandom_range(0, 1) ? lkvc_pkg::MODE_PUT : lkvc_pkg::MODE_GET,
                      key, pick_value());
      end
   endtask

   // The sender stops mid-stream until all lookup results are back, then carries on.
   task automatic test_pause_until_drained();
      test_random_traffic(40, 20);
      wait_for_results();
      @(negedge clock);
      test_random_traffic(40, 20);
   endtask

   // Receiver readiness, with random stalls.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // Compares each result transfer with the oldest expected lookup result.
   always @(posedge clock) begin : check_results
      lookup_result_type wanted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_lookups.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("Unexpected result transfer: found=%0b read_value=%h",
                        rsp_tuser, rsp_tdata);
            end
         end else begin
            wanted = pending_lookups.pop_front();
            if (rsp_tuser !== wanted.found || rsp_tdata !== wanted.read_value) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("Lookup mismatch: exp found=%0b value=%h, got found=%0b value=%h",
                           wanted.found, wanted.read_value, rsp_tuser, rsp_tdata);
               end
            end
         end
      end
   end

   // Stimulus sequence.
   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      req_tuser          = lkvc_pkg::MODE_GET;
      rsp_tready         = 1'b0;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      mismatch_count     = 0;
      mirror_fill        = 0;
      mirror_capacity    = lkvc_pkg::CAP_RESET;
      sender_idle_pct    = 20;
      receiver_stall_pct = 46;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_lookup_and_update();
      test_capacity_trim();

      // Sender idles a little, receiver stalls often; capacity above the store size.
      set_capacity(5'd31);
      test_random_traffic(160, 20);
      test_pause_until_drained();
      test_random_traffic(140, 20);

      // Sender idles often, receiver stalls a little.
      sender_idle_pct    = 46;
      receiver_stall_pct = 20;
      set_capacity(lkvc_pkg::CAP_W'($urandom_range(2, 15)));
      test_random_traffic(250, 12);
      set_capacity(5'd1);
      test_random_traffic(60, 3);

      // Back-to-back transfers on both sides.
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      set_capacity(5'd16);
      test_random_traffic(150, 20);

      // Wait for the last lookup results, within a bound.
      req_tvalid <= 1'b0;
      for (int i = 0; i < DRAIN_LIMIT && pending_lookups.size() != 0; i++) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && pending_lookups.size() == 0) begin
         $display("tb_lru_key_value_cache: PASS");
      end else begin
         $display("tb_lru_key_value_cache: FAIL");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("tb_lru_key_value_cache: FAIL");
      $finish;
   end

endmodule

[lru_key_value_cache.f]
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_ram.sv
rtl/core/lru_key_value_cache.sv
rtl/core/lkvc_checker.sv
dv/tb_lru_key_value_cache.sv
